>>> hdl/threshold_heart_rate_averager_unit_defines.svh
// Assertion macros for the heart-rate averager top level.
`ifndef THRESHOLD_HEART_RATE_AVERAGER_UNIT_DEFINES_SVH
`define THRESHOLD_HEART_RATE_AVERAGER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clock edge outside reset
`define THRA_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heart-rate averager check failed");

// next-cycle implication
`define THRA_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heart-rate averager check failed");

`endif

>>> hdl/thra_pkg.sv
// Shared constants and controller/datapath command and status types.
package thra_pkg;

   localparam int THRA_ENTRIES   = 8;
   localparam int THRA_SAMPLE_W  = 12;
   localparam int THRA_TIME_W    = 48;
   localparam int THRA_BPM_W     = 16;
   localparam int THRA_RATE_W    = 24;
   localparam int THRA_FRAC_W    = 8;
   localparam int THRA_DIV_STEPS = THRA_RATE_W;
   localparam int THRA_CNT_W     = $clog2(THRA_DIV_STEPS);

   // 60000 bpm-ms scaled to 16.8 fixed point
   localparam logic [THRA_RATE_W-1:0]   THRA_RATE_NUM  = 24'd15360000;
   localparam logic [THRA_SAMPLE_W-1:0] THRA_THR_RESET = 12'd2048;

   typedef struct packed {
      logic load_in;        // capture the request beat
      logic mem_read;       // fetch the slot about to be replaced
      logic div_load_rate;  // start rate division
      logic div_step;       // one restoring-division iteration
      logic update;         // write slot, update running sum
      logic emit;           // average the sum into the result register
   } thra_cmd_type;

   typedef struct packed {
      logic beat_ok;        // sample above threshold and interval positive
      logic out_free;       // result register can take a value this cycle
   } thra_stat_type;

endpackage

>>> hdl/thra_if.sv
// Request and response channel interfaces.
interface thra_req_if;
   import thra_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [THRA_SAMPLE_W-1:0] sample;
   logic [THRA_TIME_W-1:0]   time_ms;

   modport source (output valid, output sample, output time_ms, input ready);
   modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface thra_rsp_if;
   import thra_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [THRA_BPM_W-1:0] bpm;

   modport source (output valid, output bpm, input ready);
   modport sink   (input valid, input bpm, output ready);
endinterface

>>> hdl/thra_ctrl.sv
// Sequencing state machine for the heart-rate averager.
module thra_ctrl
   import thra_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  thra_stat_type stat,
   output thra_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_CHECK    = 5'b00010,
      ST_DIV_RATE = 5'b00100,
      ST_UPDATE   = 5'b01000,
      ST_EMIT     = 5'b10000
   } state_type;

   localparam logic [THRA_CNT_W-1:0] LAST_STEP = THRA_CNT_W'(THRA_DIV_STEPS - 1);

   state_type             state_ff, state_in;
   logic [THRA_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.mem_read = 1'b1;
            cnt_in       = '0;
            if (stat.beat_ok) begin
               cmd.div_load_rate = 1'b1;
               state_in          = ST_DIV_RATE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_RATE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hdl/thra_dp.sv
// Datapath: threshold test, rate ring, running sum, serial rate divider, averaging multiplier.
module thra_dp
   import thra_pkg::*;
#(
   parameter int ENTRIES = THRA_ENTRIES,
   parameter int IDX_W   = $clog2(ENTRIES),
   parameter int SUM_W   = THRA_RATE_W + $clog2(ENTRIES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [THRA_SAMPLE_W-1:0] csr_wdata,
   input  logic [THRA_SAMPLE_W-1:0] in_sample,
   input  logic [THRA_TIME_W-1:0]   in_time,
   input  thra_cmd_type             cmd,
   output thra_stat_type            stat,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [THRA_BPM_W-1:0]    rsp_bpm
);

   localparam int RW = THRA_RATE_W;
   localparam int TW = THRA_TIME_W;

   // average = floor((sum >> 8) / ENTRIES) by exact reciprocal multiplication
   localparam int AVG_IN_W  = SUM_W - THRA_FRAC_W;
   localparam int MUL_W     = AVG_IN_W + 1;
   localparam int AVG_SHIFT = AVG_IN_W + $clog2(ENTRIES);
   localparam logic [MUL_W-1:0] AVG_MUL =
      MUL_W'(((64'd1 << AVG_SHIFT) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

   logic [THRA_SAMPLE_W-1:0] thr_ff, thr_in;
   logic [THRA_SAMPLE_W-1:0] sample_ff;
   logic [TW-1:0]            time_ff;
   logic [TW-1:0]            last_ff, last_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ENTRIES-1:0]       valid_ff, valid_in;
   logic [RW-1:0]            ring_mem [ENTRIES];
   logic [RW-1:0]            rd_ff;
   logic                     rdv_ff;
   logic [SUM_W-1:0]         total_ff, total_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [RW-1:0]            quo_ff, quo_in;
   logic [TW-1:0]            den_ff, den_in;
   logic                     out_valid_ff, out_valid_in;
   logic [THRA_BPM_W-1:0]    bpm_ff, bpm_in;

   logic [RW:0]                 trial;
   logic                        fits;
   logic [RW:0]                 diff;
   logic [RW-1:0]               old_rate;
   logic [AVG_IN_W+MUL_W-1:0]   avg_prod;

   // restoring division step; remainder never exceeds the numerator prefix
   assign trial    = {rem_ff, quo_ff[RW-1]};
   assign fits     = {{(TW-RW-1){1'b0}}, trial} >= den_ff;
   assign diff     = trial - den_ff[RW:0];
   assign old_rate = rdv_ff ? rd_ff : '0;
   assign avg_prod = total_ff[SUM_W-1:THRA_FRAC_W] * AVG_MUL;

   assign stat.beat_ok  = (sample_ff > thr_ff) && (time_ff > last_ff);
   assign stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      thr_in       = csr_we ? csr_wdata : thr_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      out_valid_in = out_valid_ff;
      bpm_in       = bpm_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.div_load_rate) begin
         rem_in = '0;
         quo_in = THRA_RATE_NUM;
         den_in = time_ff - last_ff;
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[RW-1:0] : trial[RW-1:0];
         quo_in = {quo_ff[RW-2:0], fits};
      end
      if (cmd.update) begin
         // quo_ff holds the new 16.8 rate here
         total_in        = total_ff - SUM_W'(old_rate) + SUM_W'(quo_ff);
         valid_in[idx_ff] = 1'b1;
         last_in         = time_ff;
         idx_in          = (idx_ff == IDX_W'(ENTRIES - 1)) ? '0 : idx_ff + 1'b1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         bpm_in       = avg_prod[AVG_SHIFT +: THRA_BPM_W];
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[idx_ff] <= quo_ff;
      end
      if (cmd.mem_read) begin
         rd_ff <= ring_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rdv_ff <= valid_ff[idx_ff];
      end
      if (cmd.load_in) begin
         sample_ff <= in_sample;
         time_ff   <= in_time;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      bpm_ff <= bpm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRA_THR_RESET;
         last_ff      <= '0;
         idx_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_bpm   = bpm_ff;

endmodule

>>> hdl/threshold_heart_rate_averager_unit.sv
// Top level of the threshold beat detector with moving-average heart rate.
//
//  - req_ch carries one sensor beat: a 12-bit sample and its 48-bit ms timestamp.
//  - A sample strictly above the threshold is a beat (level test). If its
//    timestamp is later than the last beat's, one bpm beat leaves on rsp_ch;
//    otherwise the request produces nothing and no state changes.
//  - csr_we/csr_wdata write the 12-bit threshold; write only while idle.
//  - Sequence: a request that gives no result passes capture and test only.
//    A beat reaches the result register through capture and test,
//    24 restoring-divider iterations for 60000*256/interval, one step to
//    replace the ring slot and adjust the running sum, and one for the
//    average (reciprocal multiply by 1/ENTRIES) into the result register.
//    The request side is freed again once the result is emitted.
//  - One request at a time: req_ch.ready is high only between requests.
//  - The bpm waits in an output register, so the next request is taken meanwhile;
//    a beat finished while rsp_ch is stalled holds in the emit step until it frees.
//  - Reset (synchronous, active high) empties the ring at once through
//    per-slot valid bits, zeroes the sum, index and last beat time, and
//    sets the threshold to 2048. No clearing pass is needed.
`include "threshold_heart_rate_averager_unit_defines.svh"

module threshold_heart_rate_averager_unit
   import thra_pkg::*;
#(
   parameter int ENTRIES = THRA_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   thra_req_if.sink                 req_ch,
   thra_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [THRA_SAMPLE_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int SUM_W = THRA_RATE_W + $clog2(ENTRIES);

   thra_cmd_type  ctrl_cmd;
   thra_stat_type dp_stat;

   // sequencer: owns the request handshake and the division iteration count
   thra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // datapath: ring, sum, divider, averaging multiplier and the result register
   thra_dp #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .SUM_W   (SUM_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_sample (req_ch.sample),
      .in_time   (req_ch.time_ms),
      .cmd       (ctrl_cmd),
      .stat      (dp_stat),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_bpm   (rsp_ch.bpm)
   );

   // one request in flight: the beat after acceptance is never taken
   `THRA_CHECK_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // a result appears only through the emit step
   `THRA_CHECK_NOW(a_rsp_from_emit, clock, reset, $rose(rsp_ch.valid), $past(ctrl_cmd.emit))
   // a taken result is not repeated unless a new one was emitted
   `THRA_CHECK_NEXT(a_no_repeat, clock, reset,
                    rsp_ch.valid && rsp_ch.ready && !ctrl_cmd.emit, !rsp_ch.valid)

endmodule

>>> tb/tb_threshold_heart_rate_averager_unit.sv
// Self-checking testbench for the threshold heart-rate averager unit.
`timescale 1ns / 100ps

module tb_threshold_heart_rate_averager_unit;
   import thra_pkg::*;

   // Cycles with no beat accepted on either channel before the run is abandoned.
   // The worst honest stretch is the long response hold plus one beat's latency.
   localparam int WATCHDOG_LIMIT = 3000;
   // Long receiver hold, long enough to back the block up into its request side.
   localparam int LONG_HOLD      = 400;
   // Margin that lets a beat run through the block before a threshold change.
   localparam int SETTLE_CYCLES  = 64;

   typedef struct packed {
      logic [THRA_SAMPLE_W-1:0] sample;
      logic [THRA_TIME_W-1:0]   time_ms;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [THRA_SAMPLE_W-1:0] csr_wdata;

   thra_req_if req_ch ();
   thra_rsp_if rsp_ch ();

   threshold_heart_rate_averager_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Rate averager model: threshold, last beat time, ring of 16.8 rates
   // ------------------------------------------------------------------
   logic [THRA_SAMPLE_W-1:0] threshold_copy;
   logic [THRA_TIME_W-1:0]   prev_beat_ms;
   logic [THRA_RATE_W-1:0]   rate_slots [THRA_ENTRIES];
   int                       slot_ptr;

   reading_type              pending_readings [$];
   logic [THRA_BPM_W-1:0]    expected_bpm [$];

   reading_type              on_bus;
   int                       gap_left;
   int                       stall_left;
   int                       hold_left;
   bit                       long_hold_done;
   bit                       steady_run;      // no idling on either side
   int                       readings_sent;
   int                       bpm_checked;
   int                       bpm_predicted;
   int                       fault_count;
   int                       quiet_cycles;
   int                       settings_used;
   logic [THRA_BPM_W-1:0]    bpm_wanted;
   logic [THRA_TIME_W-1:0]   gen_time;        // stimulus time base

   // A sample strictly above the threshold with a later timestamp replaces
   // the current ring slot with 60000*256/interval and yields the ring mean.
   task automatic predict_bpm(input reading_type r);
      logic [THRA_TIME_W-1:0] gap_ms;
      logic [31:0]            ring_total;
      if (r.sample <= threshold_copy || r.time_ms <= prev_beat_ms)
         return;
      gap_ms = r.time_ms - prev_beat_ms;
      rate_slots[slot_ptr] = THRA_RATE_W'(THRA_TIME_W'(THRA_RATE_NUM) / gap_ms);
      ring_total = '0;
      for (int i = 0; i < THRA_ENTRIES; i++)
         ring_total += rate_slots[i];
      expected_bpm.push_back(THRA_BPM_W'(ring_total / (THRA_ENTRIES * 256)));
      bpm_predicted++;
      prev_beat_ms = r.time_ms;
      slot_ptr = (slot_ptr + 1) % THRA_ENTRIES;
   endtask

   // ------------------------------------------------------------------
   // Request driver: pops pending readings, holds while the block is busy
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_bpm(on_bus);
            readings_sent++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // beat still on offer, keep it steady
         end else if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (pending_readings.size() != 0 && !steady_run &&
                      $urandom_range(0, 4) == 0) begin
            // idle burst before the next reading
            req_ch.valid <= 1'b0;
            gap_left     <= $urandom_range(0, 2);
         end else if (pending_readings.size() != 0) begin
            on_bus = pending_readings.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.sample  <= on_bus.sample;
            req_ch.time_ms <= on_bus.time_ms;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response ready: short random stalls, one long hold to back up the block
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         stall_left     <= 0;
         hold_left      <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!long_hold_done && bpm_checked >= 40) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_ch.ready   <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!steady_run && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: each bpm beat against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bpm.size() == 0) begin
            $error("bpm beat with nothing expected: got %0d", rsp_ch.bpm);
            fault_count++;
         end else begin
            bpm_wanted = expected_bpm.pop_front();
            if (rsp_ch.bpm !== bpm_wanted) begin
               $error("bpm mismatch: expected %0d, got %0d", bpm_wanted, rsp_ch.bpm);
               fault_count++;
            end
         end
         bpm_checked <= bpm_checked + 1;
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake", quiet_cycles);
         $display("threshold_heart_rate_averager_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Wait until every reading is taken and every bpm is back, then let the
   // block finish any beat that gives no result before the threshold moves.
   task automatic drain_block();
      while (pending_readings.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (expected_bpm.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRA_SAMPLE_W-1:0] thr);
      @(posedge clock);
      csr_we         <= 1'b1;
      csr_wdata      <= thr;
      threshold_copy = thr;
      settings_used++;
      @(posedge clock);
      csr_we         <= 1'b0;
   endtask

   task automatic push_reading(input logic [THRA_SAMPLE_W-1:0] s,
                               input logic [THRA_TIME_W-1:0] t);
      pending_readings.push_back('{sample: s, time_ms: t});
   endtask

   // Mostly well-formed beat trains with plausible intervals; the rest is
   // sub-threshold samples, wild timestamps and beats going back in time.
   // count is the number of readings queued, of every kind.
   task automatic queue_random_phase(input logic [THRA_SAMPLE_W-1:0] thr,
                                     input int count);
      int                       kind;
      int                       taken;
      logic [THRA_SAMPLE_W-1:0] s;
      logic [THRA_TIME_W-1:0]   step;
      taken = 0;
      while (taken < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            s = (thr == {THRA_SAMPLE_W{1'b1}}) ? THRA_SAMPLE_W'($urandom)
                                               : THRA_SAMPLE_W'($urandom_range(thr + 1, 4095));
            case ($urandom_range(0, 9))
               0, 1:    step = $urandom_range(1, 299);
               2:       step = $urandom_range(2001, 20000000);
               3:       step = 0;
               4:       step = {16'd0, 32'($urandom)} << $urandom_range(0, 4);
               default: step = $urandom_range(300, 2000);
            endcase
            gen_time += step;
            push_reading(s, gen_time);
            taken++;
         end else if (kind < 85) begin
            push_reading(THRA_SAMPLE_W'($urandom_range(0, thr)),
                         gen_time + $urandom_range(0, 500));
            taken++;
         end else if (kind < 93) begin
            push_reading(THRA_SAMPLE_W'($urandom_range(0, thr)),
                         {16'($urandom), 32'($urandom)});
            taken++;
         end else begin
            s = (thr == {THRA_SAMPLE_W{1'b1}}) ? THRA_SAMPLE_W'($urandom)
                                               : THRA_SAMPLE_W'($urandom_range(thr + 1, 4095));
            push_reading(s, gen_time - $urandom_range(0, 1000));
            taken++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.time_ms = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      threshold_copy = THRA_THR_RESET;
      prev_beat_ms   = '0;
      slot_ptr       = 0;
      for (int i = 0; i < THRA_ENTRIES; i++)
         rate_slots[i] = '0;
      steady_run     = 1'b0;
      readings_sent  = 0;
      bpm_checked    = 0;
      bpm_predicted  = 0;
      fault_count    = 0;
      quiet_cycles   = 0;
      settings_used  = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset threshold: at-threshold sample, zero interval, one-ms interval
      // filling the ring to the 60000 ceiling, then a backward beat.
      push_reading(12'd2048, 48'd5);
      push_reading(12'd0, 48'd0);
      push_reading(12'd2049, 48'd0);
      push_reading(12'd4095, 48'd1);
      push_reading(12'd4095, 48'd1);
      for (int t = 2; t <= 9; t++)
         push_reading(12'd3000, THRA_TIME_W'(t));
      push_reading(12'd4095, 48'd0);
      // rate of one, rate truncated to zero, jump onto the top time bit
      push_reading(12'd2500, 48'd1009);
      push_reading(12'd2500, 48'd1009 + 48'd15360000);
      push_reading(12'd2500, 48'd1009 + 48'd15360000 + 48'd15360001);
      push_reading(12'd4095, 48'h8000_0000_0000);
      push_reading(12'd2049, 48'h8000_0000_0320);
      drain_block();

      // Lowest threshold: zero is no beat, one is
      write_threshold('0);
      push_reading(12'd0, 48'h8000_0000_0708);
      push_reading(12'd1, 48'h8000_0000_06a4);
      drain_block();

      // Highest threshold: nothing can be a beat
      write_threshold({THRA_SAMPLE_W{1'b1}});
      push_reading(12'd4095, 48'h8000_0000_0a00);
      push_reading(12'd4095, 48'hffff_ffff_ffff);
      drain_block();

      gen_time = 48'h8000_0000_06a4;

      // Random phases over a spread of thresholds
      write_threshold(THRA_SAMPLE_W'($urandom_range(1, 4094)));
      queue_random_phase(threshold_copy, 480);
      drain_block();

      write_threshold('0);
      queue_random_phase(threshold_copy, 420);
      drain_block();

      write_threshold(THRA_SAMPLE_W'($urandom_range(3000, 4094)));
      queue_random_phase(threshold_copy, 380);
      drain_block();

      write_threshold({THRA_SAMPLE_W{1'b1}});
      queue_random_phase(threshold_copy, 40);
      drain_block();

      // Closing stretch runs flat out, ending on the latest possible timestamp
      steady_run = 1'b1;
      write_threshold(THRA_SAMPLE_W'($urandom_range(1, 1500)));
      queue_random_phase(threshold_copy, 630);
      push_reading(12'd4095, 48'hffff_ffff_ffff);
      drain_block();

      $display("ran %0d sensor readings over %0d threshold settings,",
               readings_sent, settings_used);
      $display("%0d bpm results predicted and %0d checked", bpm_predicted, bpm_checked);
      if (fault_count == 0)
         $display("threshold_heart_rate_averager_unit regression: pass");
      else
         $display("threshold_heart_rate_averager_unit regression: fail");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/thra_pkg.sv
hdl/thra_if.sv
hdl/thra_ctrl.sv
hdl/thra_dp.sv
hdl/threshold_heart_rate_averager_unit.sv
tb/tb_threshold_heart_rate_averager_unit.sv
